// ===== design/bffa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the bitmap first-fit block allocator.
// No dependencies.
package bffa_pkg;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NULL    = 2'd1;
  localparam logic [1:0] ST_NOFIT   = 2'd2;
  localparam logic [1:0] ST_OUTSIDE = 2'd3;

  localparam logic [31:0] RESET_BASE = 32'h2000_1000;

  // register index 0 decodes from paddr bit 2
  localparam logic REG_HEAP_BASE = 1'b0;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] request_bytes;
    logic [31:0] free_address;
  } cmd_t;

  typedef struct packed {
    logic [31:0] block_address;
    logic [1:0]  status;
  } res_t;

  // strobes and write data toward the map memory
  typedef struct packed {
    logic re;
    logic we;
    logic wdata;
  } mem_ctl_t;

endpackage

// ===== design/bitmap_first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// Top level: APB register for the heap base, command engine, used-map memory.
// Depends on bffa_pkg, bffa_engine, bffa_map_ram.
//
//  channel   ports                                    handshake
//  command   start, busy, item (cmd_t)                taken when start && !busy
//  result    done, result (res_t)                     one-cycle strobe, no stall
//  config    psel penable pwrite paddr pwdata prdata  APB, pready tied high
//
// Allocate: map scan, one block per cycle through the single read port, then
// the blocks of the run are marked, then a reply state answers.
// Free: range check, block-index computation (S_FMUL, S_FFIX, S_FCORR), then
// blocks are released in order until a free one or the map end. Clear: every
// map entry is swept. Zero-size, null, out-of-heap and unused commands answer
// in the cycle after they are taken. After reset the map is swept with busy high.
// Results are never held off; each is shown for exactly one cycle.
module bitmap_first_fit_block_allocator import bffa_pkg::*; #(
  parameter int NUM_BLOCKS  = 256,
  parameter int BLOCK_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cmd_t        item,
  output logic        busy,
  output logic        done,
  output res_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(NUM_BLOCKS);

  logic [31:0]   heap_base_address;
  mem_ctl_t      mem_ctl;
  logic [IW-1:0] mem_raddr;
  logic [IW-1:0] mem_waddr;
  logic          mem_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEAP_BASE) ? heap_base_address : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base_address <= RESET_BASE;
    end else if (psel && penable && pwrite && (paddr[2] == REG_HEAP_BASE)) begin
      heap_base_address <= pwdata;
    end
  end

  bffa_engine #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .base      (heap_base_address),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .mem_ctl   (mem_ctl),
    .mem_raddr (mem_raddr),
    .mem_waddr (mem_waddr),
    .mem_rdata (mem_rdata)
  );

  bffa_map_ram #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_map (
    .clk   (clk),
    .ctl   (mem_ctl),
    .raddr (mem_raddr),
    .waddr (mem_waddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== design/bffa_map_ram.sv =====
`timescale 1ns / 1ps
// One-bit-wide used map: one write port, one registered read port.
// Depends on bffa_pkg.
module bffa_map_ram import bffa_pkg::*; #(
  parameter int NUM_BLOCKS = 256
) (
  input  logic                          clk,
  input  mem_ctl_t                      ctl,
  input  logic [$clog2(NUM_BLOCKS)-1:0] raddr,
  input  logic [$clog2(NUM_BLOCKS)-1:0] waddr,
  output logic                          rdata
);

  logic mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= ctl.wdata;
    end
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bffa_engine.sv =====
`timescale 1ns / 1ps
// Command sequencer: scans, marks, frees and sweeps the used map.
// Depends on bffa_pkg; drives one bffa_map_ram.
module bffa_engine import bffa_pkg::*; #(
  parameter int NUM_BLOCKS  = 256,
  parameter int BLOCK_BYTES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  cmd_t                          item,
  input  logic [31:0]                   base,
  output logic                          busy,
  output logic                          done,
  output res_t                          result,
  output mem_ctl_t                      mem_ctl,
  output logic [$clog2(NUM_BLOCKS)-1:0] mem_raddr,
  output logic [$clog2(NUM_BLOCKS)-1:0] mem_waddr,
  input  logic                          mem_rdata
);

  localparam int IW   = $clog2(NUM_BLOCKS);
  localparam int CW   = $clog2(NUM_BLOCKS + 1);
  localparam int HEAP = NUM_BLOCKS * BLOCK_BYTES;
  localparam int OW   = $clog2(HEAP);
  localparam int RW   = OW + 1;
  localparam int MW   = OW + RW;
  localparam int BBW  = $clog2(BLOCK_BYTES + 1);
  localparam int PW   = IW + BBW;
  localparam int RBW  = $clog2(HEAP + 1);
  localparam int SW   = (RBW > 16) ? RBW : 16;

  // floor(2^OW / BLOCK_BYTES); the quotient estimate is at most one low
  localparam logic [RW-1:0] RECIP    = RW'((64'd1 << OW) / BLOCK_BYTES);
  localparam logic [CW-1:0] END_IDX  = CW'(NUM_BLOCKS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BLOCKS - 1);
  localparam logic [32:0]   HEAP_LIM = 33'(HEAP);
  localparam logic [SW-1:0] BB_S     = SW'(BLOCK_BYTES);
  localparam logic [31:0]   BB_32    = 32'(BLOCK_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_SWEEP, S_ASCAN, S_AMARK, S_AREPLY, S_FMUL, S_FFIX, S_FCORR, S_FSCAN
  } state_t;

  state_t        state;
  logic [CW-1:0] rd_idx;
  logic          pend;
  logic [IW-1:0] pend_idx;
  logic [CW-1:0] run;
  logic [SW-1:0] run_b;
  logic [SW-1:0] need_b;
  logic [IW-1:0] first;
  logic [IW-1:0] last;
  logic [IW-1:0] wr_idx;
  logic [PW-1:0] offs;
  logic [OW-1:0] off;
  logic [OW-1:0] back;
  logic [IW-1:0] q;
  logic [IW-1:0] clr_idx;
  logic          sweep_reply;

  logic          issue;
  logic [CW-1:0] run_next;
  logic [SW-1:0] run_b_next;
  logic [CW-1:0] first_full;
  logic [31:0]   off_full;
  logic [MW-1:0] prod;
  logic [PW-1:0] qb;
  logic [PW-1:0] first_b;

  assign busy       = (state != S_IDLE);
  assign issue      = ((state == S_ASCAN) || (state == S_FSCAN)) && (rd_idx != END_IDX);
  assign run_next   = run + CW'(1);
  assign run_b_next = run_b + BB_S;
  assign first_full = CW'(pend_idx) + CW'(1) - run_next;
  assign off_full   = item.free_address - base;
  assign prod       = MW'(off) * MW'(RECIP);
  assign qb         = PW'(q) * PW'(BLOCK_BYTES);
  assign first_b    = PW'(first) * PW'(BLOCK_BYTES);
  assign mem_raddr  = rd_idx[IW-1:0];

  always_comb begin
    mem_ctl.re    = issue;
    mem_ctl.we    = 1'b0;
    mem_ctl.wdata = 1'b0;
    mem_waddr     = pend_idx;
    unique case (state)
      S_SWEEP: begin
        mem_ctl.we = 1'b1;
        mem_waddr  = clr_idx;
      end
      S_AMARK: begin
        mem_ctl.we    = 1'b1;
        mem_ctl.wdata = 1'b1;
        mem_waddr     = wr_idx;
      end
      S_FSCAN: begin
        mem_ctl.we = pend && mem_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      clr_idx     <= '0;
      sweep_reply <= 1'b0;
      pend        <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (item.cmd)
              CMD_ALLOC: begin
                if (item.request_bytes == 16'd0) begin
                  done   <= 1'b1;
                  result <= '{block_address: 32'd0, status: ST_NULL};
                end else begin
                  need_b <= SW'(item.request_bytes);
                  rd_idx <= '0;
                  pend   <= 1'b0;
                  run    <= '0;
                  run_b  <= '0;
                  state  <= S_ASCAN;
                end
              end
              CMD_FREE: begin
                priority if (item.free_address == 32'd0) begin
                  done   <= 1'b1;
                  result <= '{block_address: 32'd0, status: ST_NULL};
                end else if (item.free_address < base) begin
                  done   <= 1'b1;
                  result <= '{block_address: 32'd0, status: ST_OUTSIDE};
                end else if ({1'b0, off_full} >= HEAP_LIM) begin
                  done   <= 1'b1;
                  result <= '{block_address: 32'd0, status: ST_OUTSIDE};
                end else begin
                  off   <= off_full[OW-1:0];
                  state <= S_FMUL;
                end
              end
              CMD_CLEAR: begin
                clr_idx     <= '0;
                sweep_reply <= 1'b1;
                state       <= S_SWEEP;
              end
              default: begin
                done   <= 1'b1;
                result <= '{block_address: 32'd0, status: ST_DONE};
              end
            endcase
          end
        end
        S_SWEEP: begin
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
            if (sweep_reply) begin
              done   <= 1'b1;
              result <= '{block_address: 32'd0, status: ST_DONE};
            end
          end else begin
            clr_idx <= clr_idx + IW'(1);
          end
        end
        S_ASCAN: begin
          pend     <= issue;
          pend_idx <= rd_idx[IW-1:0];
          if (issue) begin
            rd_idx <= rd_idx + CW'(1);
          end
          priority if (pend) begin
            if (!mem_rdata) begin
              run   <= run_next;
              run_b <= run_b_next;
              if (run_b_next >= need_b) begin
                first  <= first_full[IW-1:0];
                wr_idx <= first_full[IW-1:0];
                last   <= pend_idx;
                pend   <= 1'b0;
                state  <= S_AMARK;
              end
            end else begin
              run   <= '0;
              run_b <= '0;
            end
          end else if (rd_idx == END_IDX) begin
            done   <= 1'b1;
            result <= '{block_address: 32'd0, status: ST_NOFIT};
            state  <= S_IDLE;
          end else begin
          end
        end
        S_AMARK: begin
          offs <= first_b;
          if (wr_idx == last) begin
            state <= S_AREPLY;
          end else begin
            wr_idx <= wr_idx + IW'(1);
          end
        end
        S_AREPLY: begin
          done   <= 1'b1;
          result <= '{block_address: base + 32'(offs), status: ST_DONE};
          state  <= S_IDLE;
        end
        S_FMUL: begin
          q     <= IW'(prod >> OW);
          state <= S_FFIX;
        end
        S_FFIX: begin
          back  <= qb[OW-1:0];
          state <= S_FCORR;
        end
        S_FCORR: begin
          if ((32'(off) - 32'(back)) >= BB_32) begin
            rd_idx <= CW'(q) + CW'(1);
          end else begin
            rd_idx <= CW'(q);
          end
          pend  <= 1'b0;
          state <= S_FSCAN;
        end
        S_FSCAN: begin
          pend     <= issue;
          pend_idx <= rd_idx[IW-1:0];
          if (issue) begin
            rd_idx <= rd_idx + CW'(1);
          end
          // a free block ends the release; the read already issued is dropped
          if ((pend && !mem_rdata) || (!pend && (rd_idx == END_IDX))) begin
            pend   <= 1'b0;
            done   <= 1'b1;
            result <= '{block_address: 32'd0, status: ST_DONE};
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while engine busy");
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> (busy || done))
    else $error("accepted word produced neither work nor result");
  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
      (mem_ctl.we && mem_ctl.re) |-> (mem_waddr != mem_raddr))
    else $error("map read and write hit the same entry");
  a_fail_null: assert property (@(posedge clk) disable iff (rst)
      (done && (result.status != ST_DONE)) |-> (result.block_address == 32'd0))
    else $error("failed command returned nonzero address");
`endif

endmodule
